FILE: design/tmse_pkg.sv
// ----------------------------------------------------------------------------
// tmse_pkg
// Types, codes and sizes shared by the tape machine step engine.
// ----------------------------------------------------------------------------
package tmse_pkg;

    // sizes of the machine
    localparam int NUM_STATES      = 16;
    localparam int RULES_PER_STATE = 8;
    localparam int TAPE_DEPTH      = 1024;
    localparam int SYMBOL_WIDTH    = 8;

    localparam int STATE_W    = $clog2(NUM_STATES);
    localparam int RULE_IDX_W = $clog2(RULES_PER_STATE);
    localparam int RULE_CNT_W = $clog2(RULES_PER_STATE + 1);
    localparam int HEAD_W     = $clog2(TAPE_DEPTH);
    localparam int RULE_ADR_W = STATE_W + RULE_IDX_W;
    localparam int RULE_DEPTH = NUM_STATES * RULES_PER_STATE;

    // action codes
    localparam logic [2:0] ACT_LOAD  = 3'd0;
    localparam logic [2:0] ACT_WRITE = 3'd1;
    localparam logic [2:0] ACT_START = 3'd2;
    localparam logic [2:0] ACT_STEP  = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;

    // head move codes
    localparam logic [1:0] MV_RIGHT = 2'd0;
    localparam logic [1:0] MV_LEFT  = 2'd1;
    localparam logic [1:0] MV_HALT  = 2'd2;
    localparam logic [1:0] MV_NONE  = 2'd3;

    // run status codes
    localparam logic [1:0] RUN_ACTIVE   = 2'd0;
    localparam logic [1:0] RUN_HALTED   = 2'd1;
    localparam logic [1:0] RUN_REJECTED = 2'd2;

    // input request
    typedef struct packed {
        logic [2:0] action;
        logic [3:0] rule_state;
        logic [7:0] rule_symbol;
        logic       rule_any;
        logic [7:0] rule_write;
        logic       rule_keep;
        logic [1:0] rule_move;
        logic [3:0] rule_next;
        logic [9:0] cell_address;
        logic [7:0] tape_symbol;
    } t_in_req;

    // result
    typedef struct packed {
        logic [1:0] run_status;
        logic [3:0] machine_state;
        logic [9:0] head_position;
        logic [7:0] read_symbol;
        logic       load_error;
    } t_out_rsp;

    // one stored rule
    typedef struct packed {
        logic [SYMBOL_WIDTH-1:0] sym;
        logic                    any;
        logic [SYMBOL_WIDTH-1:0] wr;
        logic                    keep;
        logic [1:0]              move;
        logic [STATE_W-1:0]      next;
    } t_rule;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_READ,
        S_DONE
    } t_fsm;

endpackage

FILE: design/tape_machine_step_engine_core.sv
// ----------------------------------------------------------------------------
// tape_machine_step_engine_core
// Single-tape state machine engine: rule store, tape memory and a small
// sequencer that scans the current state's rules one per cycle.
// ----------------------------------------------------------------------------
// After reset the block sweeps the tape memory to blank, one cell a cycle, so
// it accepts no request until all 1024 cells are blank. Then it handles one
// request at a time: load, tape write, start and tape read go from accept
// through the execute, read and done states to the result; a step also passes
// the scan state, which tries the current state's rules in list order until one
// fires or the list runs out, and skips the scan once the machine has halted or
// rejected. The rule store has one read port and the sequencer compares one rule
// per cycle against the cell under the head.
// A finished result sits in the output register while the next request is
// accepted.
module tape_machine_step_engine_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tmse_pkg::t_in_req i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tmse_pkg::t_out_rsp o_out_rsp
);
    import tmse_pkg::*;

    // storage
    t_rule                 r_rule_mem [RULE_DEPTH];
    logic [SYMBOL_WIDTH-1:0] r_tape_mem [TAPE_DEPTH];
    logic [RULE_CNT_W-1:0] r_rule_cnt [NUM_STATES];

    // control and datapath registers
    t_fsm                    r_fsm, n_fsm;
    t_in_req                 r_req, n_req;
    logic [STATE_W-1:0]      r_cur, n_cur;
    logic [HEAD_W-1:0]       r_head, n_head;
    logic                    r_halted, n_halted;
    logic                    r_rejected, n_rejected;
    logic                    r_lerr, n_lerr;
    logic [RULE_CNT_W-1:0]   r_k, n_k;
    logic [HEAD_W-1:0]       r_clr_addr, n_clr_addr;
    logic                    r_out_valid, n_out_valid;
    t_out_rsp                r_out, n_out;
    t_rule                   r_rule_q;
    logic [SYMBOL_WIDTH-1:0] r_tape_q;

    // memory port controls
    logic                    tape_we;
    logic [HEAD_W-1:0]       tape_waddr;
    logic [SYMBOL_WIDTH-1:0] tape_wdata;
    logic                    tape_re;
    logic [HEAD_W-1:0]       tape_raddr;
    logic                    rule_we;
    logic [RULE_ADR_W-1:0]   rule_waddr;
    t_rule                   rule_wdata;
    logic [RULE_IDX_W-1:0]   rule_ridx;
    logic [STATE_W-1:0]      cnt_addr;
    logic [RULE_CNT_W-1:0]   cnt_rd;
    logic                    cnt_we;
    logic                    rule_hit;

    // rule count lookup, one address per cycle
    assign cnt_addr = (r_fsm == S_SCAN) ? r_cur : r_req.rule_state[STATE_W-1:0];
    assign cnt_rd   = r_rule_cnt[cnt_addr];

    // compare the fetched rule against the cell under the head
    assign rule_hit = r_rule_q.any ||
                      ((r_tape_q != '0) && (r_rule_q.sym == r_tape_q));

    // sequencer
    always_comb begin
        n_fsm       = r_fsm;
        n_req       = r_req;
        n_cur       = r_cur;
        n_head      = r_head;
        n_halted    = r_halted;
        n_rejected  = r_rejected;
        n_lerr      = r_lerr;
        n_k         = r_k;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        tape_we     = 1'b0;
        tape_waddr  = r_head;
        tape_wdata  = '0;
        tape_re     = 1'b0;
        tape_raddr  = r_head;
        rule_we     = 1'b0;
        rule_waddr  = {r_req.rule_state[STATE_W-1:0], cnt_rd[RULE_IDX_W-1:0]};
        rule_wdata  = '{sym:  r_req.rule_symbol[SYMBOL_WIDTH-1:0],
                        any:  r_req.rule_any,
                        wr:   r_req.rule_write[SYMBOL_WIDTH-1:0],
                        keep: r_req.rule_keep,
                        move: r_req.rule_move,
                        next: r_req.rule_next[STATE_W-1:0]};
        rule_ridx   = '0;
        cnt_we      = 1'b0;
        o_in_ready  = 1'b0;

        // output register drains independently
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_fsm)
            // blank the tape after reset
            S_CLEAR: begin
                tape_we    = 1'b1;
                tape_waddr = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == HEAD_W'(TAPE_DEPTH - 1)) begin
                    n_fsm = S_IDLE;
                end
            end
            // wait for a request
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_req = i_in_req;
                    n_fsm = S_EXEC;
                end
            end
            // dispatch on the action
            S_EXEC: begin
                n_lerr = 1'b0;
                n_fsm  = S_READ;
                case (r_req.action)
                    ACT_LOAD: begin
                        if (cnt_rd >= RULE_CNT_W'(RULES_PER_STATE)) begin
                            n_lerr = 1'b1;
                        end else begin
                            rule_we = 1'b1;
                            cnt_we  = 1'b1;
                        end
                    end
                    ACT_WRITE: begin
                        tape_we    = 1'b1;
                        tape_waddr = r_req.cell_address[HEAD_W-1:0];
                        tape_wdata = r_req.tape_symbol[SYMBOL_WIDTH-1:0];
                    end
                    ACT_START: begin
                        n_cur      = '0;
                        n_head     = '0;
                        n_halted   = 1'b0;
                        n_rejected = 1'b0;
                    end
                    ACT_STEP: begin
                        if (!r_halted && !r_rejected) begin
                            // fetch the cell and the first rule
                            tape_re = 1'b1;
                            n_k     = '0;
                            n_fsm   = S_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // one rule per cycle, next rule fetched alongside
            S_SCAN: begin
                rule_ridx = RULE_IDX_W'(r_k + 1'b1);
                n_k       = r_k + 1'b1;
                if (r_k >= cnt_rd) begin
                    n_rejected = 1'b1;
                    n_fsm      = S_READ;
                end else if (rule_hit) begin
                    n_cur      = r_rule_q.next;
                    tape_we    = !r_rule_q.keep;
                    tape_wdata = r_rule_q.wr;
                    case (r_rule_q.move)
                        MV_RIGHT: begin
                            if (r_head == HEAD_W'(TAPE_DEPTH - 1)) begin
                                n_rejected = 1'b1;
                            end else begin
                                n_head = r_head + 1'b1;
                            end
                        end
                        MV_LEFT: begin
                            if (r_head == '0) begin
                                n_rejected = 1'b1;
                            end else begin
                                n_head = r_head - 1'b1;
                            end
                        end
                        MV_HALT: begin
                            n_halted = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                    n_fsm = S_READ;
                end
            end
            // fetch the reported cell
            S_READ: begin
                tape_re = 1'b1;
                if (r_req.action == ACT_READ) begin
                    tape_raddr = r_req.cell_address[HEAD_W-1:0];
                end
                n_fsm = S_DONE;
            end
            // hand the result to the output register
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid             = 1'b1;
                    n_out.run_status        = r_rejected ? RUN_REJECTED :
                                              (r_halted ? RUN_HALTED : RUN_ACTIVE);
                    n_out.machine_state     = 4'(r_cur);
                    n_out.head_position     = 10'(r_head);
                    n_out.read_symbol       = 8'(r_tape_q);
                    n_out.load_error        = r_lerr;
                    n_fsm                   = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_CLEAR;
            r_cur       <= '0;
            r_head      <= '0;
            r_halted    <= 1'b0;
            r_rejected  <= 1'b0;
            r_lerr      <= 1'b0;
            r_k         <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_cur       <= n_cur;
            r_head      <= n_head;
            r_halted    <= n_halted;
            r_rejected  <= n_rejected;
            r_lerr      <= n_lerr;
            r_k         <= n_k;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_out <= n_out;
    end

    // per-state rule counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_STATES; s++) begin
                r_rule_cnt[s] <= '0;
            end
        end else if (cnt_we) begin
            r_rule_cnt[cnt_addr] <= cnt_rd + 1'b1;
        end
    end

    // rule store, registered read
    always_ff @(posedge i_clk) begin
        if (rule_we) begin
            r_rule_mem[rule_waddr] <= rule_wdata;
        end
        r_rule_q <= r_rule_mem[{r_cur, rule_ridx}];
    end

    // tape memory, registered read
    always_ff @(posedge i_clk) begin
        if (tape_we) begin
            r_tape_mem[tape_waddr] <= tape_wdata;
        end
        if (tape_re) begin
            r_tape_q <= r_tape_mem[tape_raddr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

FILE: verif/tape_machine_step_engine_core_tb.sv
// ----------------------------------------------------------------------------
// tape_machine_step_engine_core_tb
// Self-checking bench for the tape machine step engine: drives load, tape,
// start, step and undefined-action requests, predicts every result in the
// bench itself and checks each one, field by field, in order of arrival.
// ----------------------------------------------------------------------------
module tape_machine_step_engine_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tmse_pkg::*;

    // actions the block does not define
    localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

    localparam int CYCLE_LIMIT    = 1000000;
    localparam int PHASE_REQUESTS = 110;
    localparam int MAX_RUN_STEPS  = 24;
    localparam int DRAIN_CYCLES   = 40;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    t_in_req  in_req    = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_out_rsp out_rsp;

    // bench-side copy of the machine
    t_rule                   rule_store [NUM_STATES][RULES_PER_STATE];
    int unsigned             rule_count [NUM_STATES];
    logic [SYMBOL_WIDTH-1:0] tape_mem [TAPE_DEPTH];
    logic [STATE_W-1:0]      cur_state;
    logic [HEAD_W-1:0]       head_pos;
    logic                    is_halted;
    logic                    is_rejected;

    t_out_rsp expected_rsp [$];
    int       error_count   = 0;
    int       requests_sent = 0;
    int       cycle_count   = 0;
    int       send_idle_pct = 0;
    int       stall_pct     = 0;

    tape_machine_step_engine_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_rsp   (out_rsp)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // apply one request to the bench machine and return the result it causes
    function automatic t_out_rsp predict_response(input t_in_req req);
        t_out_rsp                rsp;
        t_rule                   rule;
        logic [SYMBOL_WIDTH-1:0] head_sym;
        logic                    found;
        int                      k;
        rsp  = '0;
        rule = '0;
        case (req.action)
            ACT_LOAD: begin
                if (int'(req.rule_state) >= NUM_STATES ||
                    rule_count[req.rule_state] >= RULES_PER_STATE) begin
                    rsp.load_error = 1'b1;
                end else begin
                    rule.sym  = req.rule_symbol[SYMBOL_WIDTH-1:0];
                    rule.any  = req.rule_any;
                    rule.wr   = req.rule_write[SYMBOL_WIDTH-1:0];
                    rule.keep = req.rule_keep;
                    rule.move = req.rule_move;
                    rule.next = req.rule_next;
                    rule_store[req.rule_state][rule_count[req.rule_state]] = rule;
                    rule_count[req.rule_state]++;
                end
            end
            ACT_WRITE: begin
                if (int'(req.cell_address) < TAPE_DEPTH)
                    tape_mem[req.cell_address] = req.tape_symbol[SYMBOL_WIDTH-1:0];
            end
            ACT_START: begin
                cur_state   = '0;
                head_pos    = '0;
                is_halted   = 1'b0;
                is_rejected = 1'b0;
            end
            ACT_STEP: begin
                if (!is_halted && !is_rejected) begin
                    head_sym = tape_mem[head_pos];
                    found    = 1'b0;
                    // first rule in list order that takes the cell wins
                    for (k = 0; k < RULES_PER_STATE; k++) begin
                        if (!found && k < rule_count[cur_state]) begin
                            rule = rule_store[cur_state][k];
                            if (rule.any || (head_sym != '0 && rule.sym == head_sym))
                                found = 1'b1;
                        end
                    end
                    if (!found) begin
                        is_rejected = 1'b1;
                    end else begin
                        cur_state = rule.next;
                        if (!rule.keep)
                            tape_mem[head_pos] = rule.wr;
                        case (rule.move)
                            MV_RIGHT: begin
                                if (int'(head_pos) + 1 >= TAPE_DEPTH)
                                    is_rejected = 1'b1;
                                else
                                    head_pos = head_pos + 1'b1;
                            end
                            MV_LEFT: begin
                                if (head_pos == '0)
                                    is_rejected = 1'b1;
                                else
                                    head_pos = head_pos - 1'b1;
                            end
                            MV_HALT: begin
                                is_halted = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            default: ;
        endcase
        rsp.run_status    = is_rejected ? RUN_REJECTED : (is_halted ? RUN_HALTED : RUN_ACTIVE);
        rsp.machine_state = cur_state;
        rsp.head_position = head_pos;
        if (req.action == ACT_READ)
            rsp.read_symbol = (int'(req.cell_address) < TAPE_DEPTH) ?
                              tape_mem[req.cell_address] : '0;
        else
            rsp.read_symbol = tape_mem[head_pos];
        return rsp;
    endfunction

    // request with every field random, then the action forced
    function automatic t_in_req random_request(input logic [2:0] act);
        logic [63:0] bits;
        t_in_req     req;
        bits       = {$urandom(), $urandom()};
        req        = bits[$bits(t_in_req)-1:0];
        req.action = act;
        return req;
    endfunction

    // mostly a small alphabet so that rules and tape meet often
    function automatic logic [7:0] pick_symbol();
        int pick;
        pick = $urandom_range(99);
        if (pick < 85)
            return 8'($urandom_range(1, 3));
        else if (pick < 90)
            return '0;
        else
            return 8'($urandom_range(255));
    endfunction

    function automatic t_in_req rule_request(input logic [3:0] state, input logic [7:0] sym,
                                             input logic any, input logic [7:0] wr,
                                             input logic keep, input logic [1:0] move,
                                             input logic [3:0] next);
        t_in_req req;
        req             = random_request(ACT_LOAD);
        req.rule_state  = state;
        req.rule_symbol = sym;
        req.rule_any    = any;
        req.rule_write  = wr;
        req.rule_keep   = keep;
        req.rule_move   = move;
        req.rule_next   = next;
        return req;
    endfunction

    function automatic t_in_req random_rule(input logic [3:0] state);
        logic [1:0] move;
        int         pick;
        pick = $urandom_range(9);
        if (pick < 4)
            move = MV_RIGHT;
        else if (pick < 6)
            move = MV_LEFT;
        else if (pick < 7)
            move = MV_HALT;
        else
            move = MV_NONE;
        return rule_request(state, pick_symbol(), ($urandom_range(3) == 0),
                            8'($urandom_range(255)) & pick_symbol(),
                            ($urandom_range(3) == 0), move, 4'($urandom_range(15)));
    endfunction

    function automatic t_in_req tape_request(input logic [2:0] act, input logic [9:0] addr,
                                             input logic [7:0] sym);
        t_in_req req;
        req              = random_request(act);
        req.cell_address = addr;
        req.tape_symbol  = sym;
        return req;
    endfunction

    // send one request and log its expected result once accepted
    task automatic send_request(input t_in_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge clk); while (!in_ready);
        expected_rsp.push_back(predict_response(req));
        requests_sent++;
    endtask

    // hold off new requests until all results are back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    // result checker and receiver stalls
    always @(posedge clk) begin : result_check
        t_out_rsp want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_rsp.size() == 0) begin
                $error("result with no request outstanding: %p", out_rsp);
                error_count++;
            end else begin
                want = expected_rsp.pop_front();
                if (out_rsp.run_status !== want.run_status) begin
                    $error("run_status: expected %0d, got %0d",
                           want.run_status, out_rsp.run_status);
                    error_count++;
                end
                if (out_rsp.machine_state !== want.machine_state) begin
                    $error("machine_state: expected %0d, got %0d",
                           want.machine_state, out_rsp.machine_state);
                    error_count++;
                end
                if (out_rsp.head_position !== want.head_position) begin
                    $error("head_position: expected %0d, got %0d",
                           want.head_position, out_rsp.head_position);
                    error_count++;
                end
                if (out_rsp.read_symbol !== want.read_symbol) begin
                    $error("read_symbol: expected 0x%02h, got 0x%02h",
                           want.read_symbol, out_rsp.read_symbol);
                    error_count++;
                end
                if (out_rsp.load_error !== want.load_error) begin
                    $error("load_error: expected %0d, got %0d",
                           want.load_error, out_rsp.load_error);
                    error_count++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // fixed sequence over every action and the corner cases of a run
    task automatic test_directed_cases();
        send_idle_pct = 0;
        stall_pct     = 0;
        // blank tape and a machine with no rules at all
        send_request(tape_request(ACT_READ, 10'd1023, 8'h00));
        send_request(random_request(ACT_STEP));
        send_request(random_request(ACT_STEP));
        send_request(random_request(ACT_UNUSED_LO));
        send_request(random_request(ACT_UNUSED_HI));
        send_request(tape_request(ACT_WRITE, 10'd1023, 8'hFF));
        send_request(tape_request(ACT_READ, 10'd1023, 8'h00));
        // blank-symbol rule is skipped, then a write and a right move
        send_request(tape_request(ACT_WRITE, 10'd0, 8'hFF));
        send_request(rule_request(4'd0, 8'h00, 1'b0, 8'hFF, 1'b0, MV_HALT, 4'd15));
        send_request(rule_request(4'd0, 8'hFF, 1'b0, 8'h00, 1'b0, MV_RIGHT, 4'd1));
        send_request(rule_request(4'd1, 8'h80, 1'b0, 8'hFF, 1'b1, MV_HALT, 4'd0));
        send_request(random_request(ACT_START));
        send_request(random_request(ACT_STEP));
        // blank cell under the head matches nothing in state 1
        send_request(random_request(ACT_STEP));
        // keep and stay, then a wildcard left move off cell 0
        send_request(tape_request(ACT_WRITE, 10'd0, 8'hFE));
        send_request(rule_request(4'd0, 8'hFE, 1'b0, 8'h12, 1'b1, MV_NONE, 4'd2));
        send_request(rule_request(4'd2, 8'h7F, 1'b1, 8'h00, 1'b0, MV_LEFT, 4'd15));
        send_request(random_request(ACT_START));
        send_request(random_request(ACT_STEP));
        send_request(random_request(ACT_STEP));
        // halt, then a step that must change nothing
        send_request(tape_request(ACT_WRITE, 10'd0, 8'hFD));
        send_request(rule_request(4'd0, 8'hFD, 1'b0, 8'hAB, 1'b0, MV_HALT, 4'd15));
        send_request(random_request(ACT_START));
        send_request(random_request(ACT_STEP));
        send_request(random_request(ACT_STEP));
    endtask

    // fill one rule list and push one load past its end
    task automatic test_full_rule_list();
        send_idle_pct = 82;
        stall_pct     = 0;
        while (rule_count[1] < RULES_PER_STATE)
            send_request(random_rule(4'd1));
        send_request(random_rule(4'd1));
    endtask

    // walk the head right across the whole tape until it falls off the end
    task automatic test_tape_end();
        int guard;
        send_idle_pct = 20;
        stall_pct     = 20;
        send_request(rule_request(4'd0, 8'hFC, 1'b0, 8'hFC, 1'b1, MV_NONE, 4'd13));
        send_request(rule_request(4'd13, 8'h00, 1'b1, 8'h00, 1'b1, MV_RIGHT, 4'd13));
        send_request(tape_request(ACT_WRITE, 10'd0, 8'hFC));
        send_request(random_request(ACT_START));
        guard = 0;
        while (!is_rejected && !is_halted && guard < TAPE_DEPTH + 8) begin
            send_request(random_request(ACT_STEP));
            guard++;
        end
        send_request(random_request(ACT_STEP));
    endtask

    // one short program: a few loads, tape set-up, start, steps until it stops
    task automatic run_program();
        int steps;
        repeat ($urandom_range(0, 2))
            send_request(random_rule(($urandom_range(3) == 0) ? 4'd0 :
                                     4'($urandom_range(15))));
        repeat ($urandom_range(0, 6))
            send_request(tape_request(ACT_WRITE, 10'($urandom_range(0, 11)), pick_symbol()));
        if ($urandom_range(9) == 0)
            wait_for_results();
        send_request(random_request(ACT_START));
        steps = 0;
        while (!is_halted && !is_rejected && steps < MAX_RUN_STEPS) begin
            send_request(random_request(ACT_STEP));
            steps++;
        end
        if ($urandom_range(3) == 0)
            send_request(random_request(ACT_STEP));
        if ($urandom_range(3) == 0)
            send_request(tape_request(ACT_READ, 10'($urandom_range(0, 15)), 8'h00));
    endtask

    // random programs and noise under each idling pattern
    task automatic test_random_programs();
        int phase;
        int target;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 82; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 82; end
                default: begin send_idle_pct = 20; stall_pct = 20; end
            endcase
            target = requests_sent + PHASE_REQUESTS;
            while (requests_sent < target) begin
                if ($urandom_range(99) < 70)
                    run_program();
                else
                    send_request(random_request(3'($urandom_range(7))));
            end
            wait_for_results();
        end
    endtask

    // main sequence
    initial begin
        for (int s = 0; s < NUM_STATES; s++)
            rule_count[s] = 0;
        for (int c = 0; c < TAPE_DEPTH; c++)
            tape_mem[c] = '0;
        cur_state   = '0;
        head_pos    = '0;
        is_halted   = 1'b0;
        is_rejected = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_full_rule_list();
        test_tape_end();
        test_random_programs();

        send_idle_pct = 0;
        stall_pct     = 0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_rsp.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
design/tmse_pkg.sv
design/tape_machine_step_engine_core.sv
verif/tape_machine_step_engine_core_tb.sv
